### rtl/med5f_pkg.sv
// shared types and constants for the five-entry median filter with level output
// used by med5f_select, med5f_level and median5_filter_with_level
package med5f_pkg;

    localparam int WINDOW_SIZE_DEF  = 5;
    localparam int SAMPLE_WIDTH_DEF = 16;

    localparam int WORD_W = 16;
    localparam int BIT_W  = $clog2(WORD_W);
    localparam int ADDR_W = 4;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [1:0]        level_t;

    localparam word_t THR_LOW_RST  = word_t'(1000);
    localparam word_t THR_MID_RST  = word_t'(2600);
    localparam word_t THR_HIGH_RST = word_t'(10000);

    localparam level_t LEVEL_LOW    = 2'd0;
    localparam level_t LEVEL_MID    = 2'd1;
    localparam level_t LEVEL_HIGH   = 2'd2;
    localparam level_t LEVEL_DANGER = 2'd3;

    typedef struct packed {
        logic             load;
        logic             step;
        logic             step_med;
        logic [BIT_W-1:0] bit_idx;
    } med5f_ctrl_t;

endpackage

### rtl/med5f_select.sv
// ring window and bit-serial radix select for the middle entry
// depends on med5f_pkg for the control struct
module med5f_select #(
    parameter int WINDOW_SIZE  = med5f_pkg::WINDOW_SIZE_DEF,
    parameter int SAMPLE_WIDTH = med5f_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  med5f_pkg::med5f_ctrl_t   ctrl,
    input  logic [SAMPLE_WIDTH-1:0]  sample,
    output logic [SAMPLE_WIDTH-1:0]  median
);

    localparam int PTR_W = $clog2(WINDOW_SIZE);
    localparam int CNT_W = $clog2(WINDOW_SIZE + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW_SIZE - 1);
    localparam logic [CNT_W-1:0] RANK_MID = CNT_W'(WINDOW_SIZE / 2);

    logic [SAMPLE_WIDTH-1:0] win_reg [WINDOW_SIZE];
    logic [PTR_W-1:0]        ptr_reg;
    logic [WINDOW_SIZE-1:0]  act_reg;
    logic [CNT_W-1:0]        rank_reg;
    logic [SAMPLE_WIDTH-1:0] med_reg;

    logic [WINDOW_SIZE-1:0]  msb;
    logic [CNT_W-1:0]        zeros;
    logic                    go_low;

    always_comb begin
        zeros = '0;
        for (int i = 0; i < WINDOW_SIZE; i++) begin
            msb[i] = win_reg[i][SAMPLE_WIDTH-1];
            zeros  = zeros + CNT_W'(act_reg[i] & ~msb[i]);
        end
        go_low = rank_reg < zeros;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < WINDOW_SIZE; i++) begin
                win_reg[i] <= '0;
            end
            ptr_reg <= '0;
        end else if (ctrl.load) begin
            for (int i = 0; i < WINDOW_SIZE; i++) begin
                if (PTR_W'(i) == ptr_reg) begin
                    win_reg[i] <= sample;
                end
            end
            ptr_reg <= (ptr_reg == PTR_LAST) ? '0 : ptr_reg + 1'b1;
        end else if (ctrl.step_med) begin
            for (int i = 0; i < WINDOW_SIZE; i++) begin
                win_reg[i] <= {win_reg[i][SAMPLE_WIDTH-2:0], win_reg[i][SAMPLE_WIDTH-1]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            act_reg  <= '1;
            rank_reg <= RANK_MID;
        end else if (ctrl.step_med) begin
            if (go_low) begin
                act_reg <= act_reg & ~msb;
            end else begin
                act_reg  <= act_reg & msb;
                rank_reg <= rank_reg - zeros;
            end
            med_reg <= {med_reg[SAMPLE_WIDTH-2:0], ~go_low};
        end
    end

    assign median = med_reg;

endmodule

### rtl/med5f_level.sv
// bit-serial compare of the raw sample against three thresholds
// depends on med5f_pkg for word, level and control types
module med5f_level #(
    parameter int SAMPLE_WIDTH = med5f_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                     aclk,
    input  med5f_pkg::med5f_ctrl_t   ctrl,
    input  logic [SAMPLE_WIDTH-1:0]  sample,
    input  med5f_pkg::word_t         thr_low,
    input  med5f_pkg::word_t         thr_mid,
    input  med5f_pkg::word_t         thr_high,
    output med5f_pkg::level_t        level
);

    med5f_pkg::word_t samp_sr_reg;
    logic [2:0]       done_reg;
    logic [2:0]       lt_reg;
    logic [2:0]       thr_bit;
    logic             samp_bit;

    always_comb begin
        thr_bit[0] = thr_low[ctrl.bit_idx];
        thr_bit[1] = thr_mid[ctrl.bit_idx];
        thr_bit[2] = thr_high[ctrl.bit_idx];
        samp_bit   = samp_sr_reg[med5f_pkg::WORD_W-1];
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            samp_sr_reg <= med5f_pkg::word_t'(sample);
            done_reg    <= '0;
            lt_reg      <= '0;
        end else if (ctrl.step) begin
            samp_sr_reg <= {samp_sr_reg[med5f_pkg::WORD_W-2:0], 1'b0};
            for (int j = 0; j < 3; j++) begin
                if (!done_reg[j] && (samp_bit != thr_bit[j])) begin
                    done_reg[j] <= 1'b1;
                    lt_reg[j]   <= thr_bit[j];
                end
            end
        end
    end

    always_comb begin
        if (lt_reg[0]) begin
            level = med5f_pkg::LEVEL_LOW;
        end else if (lt_reg[1]) begin
            level = med5f_pkg::LEVEL_MID;
        end else if (lt_reg[2]) begin
            level = med5f_pkg::LEVEL_HIGH;
        end else begin
            level = med5f_pkg::LEVEL_DANGER;
        end
    end

endmodule

### rtl/median5_filter_with_level.sv
// top level: sliding-window median filter with threshold level, apb register port
// depends on med5f_pkg, med5f_select and med5f_level
//
//  channel   ports                                   width
//  s_        s_valid s_ready s_sample                16
//  m_        m_valid m_ready m_median_value          16
//            m_speed_level                           2
//  apb       psel penable pwrite paddr pwdata prdata 4 / 32
//
// an item is loaded, then runs the serial bit steps, then is handed over
// the bit loop runs over the 16-bit threshold word; hand-over waits for a free output register
// the median is found during the last SAMPLE_WIDTH of those steps
// reset is synchronous; window, pointer and thresholds return to their defaults
// a waiting result sits in the output register while the next item is taken
module median5_filter_with_level #(
    parameter int WINDOW_SIZE  = med5f_pkg::WINDOW_SIZE_DEF,
    parameter int SAMPLE_WIDTH = med5f_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  med5f_pkg::word_t              s_sample,
    output logic                          m_valid,
    input  logic                          m_ready,
    output med5f_pkg::word_t              m_median_value,
    output med5f_pkg::level_t             m_speed_level,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [med5f_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    localparam logic [1:0] REG_LOW  = 2'd0;
    localparam logic [1:0] REG_MID  = 2'd1;
    localparam logic [1:0] REG_HIGH = 2'd2;

    localparam int BIT_W = med5f_pkg::BIT_W;
    localparam logic [BIT_W-1:0] BIT_TOP = BIT_W'(med5f_pkg::WORD_W - 1);
    localparam logic [BIT_W:0]   MED_LIM = (BIT_W + 1)'(SAMPLE_WIDTH);

    logic [1:0]             state_reg, state_next;
    logic [BIT_W-1:0]       bit_reg, bit_next;
    logic                   m_valid_reg, m_valid_next;
    med5f_pkg::word_t       med_out_reg;
    med5f_pkg::level_t      lvl_out_reg;
    med5f_pkg::word_t       thr_low_reg, thr_mid_reg, thr_high_reg;

    med5f_pkg::med5f_ctrl_t ctrl;
    logic [SAMPLE_WIDTH-1:0] sample_lo;
    logic [SAMPLE_WIDTH-1:0] median;
    med5f_pkg::level_t       level;
    logic                    out_load;
    logic                    cfg_wr;
    logic [1:0]              reg_idx;

    assign sample_lo = s_sample[SAMPLE_WIDTH-1:0];
    assign s_ready   = (state_reg == ST_IDLE);
    assign out_load  = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    always_comb begin
        ctrl.load     = s_valid && s_ready;
        ctrl.step     = (state_reg == ST_RUN);
        ctrl.step_med = (state_reg == ST_RUN) && ({1'b0, bit_reg} < MED_LIM);
        ctrl.bit_idx  = bit_reg;
    end

    always_comb begin
        state_next = state_reg;
        bit_next   = bit_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (ctrl.load) begin
                    state_next = ST_RUN;
                    bit_next   = BIT_TOP;
                end
            end
            ST_RUN: begin
                bit_next = bit_reg - 1'b1;
                if (bit_reg == '0) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            bit_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            bit_reg     <= bit_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            med_out_reg <= med5f_pkg::word_t'(median);
            lvl_out_reg <= level;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_median_value = med_out_reg;
    assign m_speed_level  = lvl_out_reg;

    // register port
    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_low_reg  <= med5f_pkg::THR_LOW_RST;
            thr_mid_reg  <= med5f_pkg::THR_MID_RST;
            thr_high_reg <= med5f_pkg::THR_HIGH_RST;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_LOW:  thr_low_reg  <= pwdata[15:0];
                REG_MID:  thr_mid_reg  <= pwdata[15:0];
                REG_HIGH: thr_high_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_LOW:  prdata = {16'b0, thr_low_reg};
            REG_MID:  prdata = {16'b0, thr_mid_reg};
            REG_HIGH: prdata = {16'b0, thr_high_reg};
            default:  prdata = '0;
        endcase
    end

    med5f_select #(
        .WINDOW_SIZE  (WINDOW_SIZE),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_select (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .sample  (sample_lo),
        .median  (median)
    );

    med5f_level #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_level (
        .aclk     (aclk),
        .ctrl     (ctrl),
        .sample   (sample_lo),
        .thr_low  (thr_low_reg),
        .thr_mid  (thr_mid_reg),
        .thr_high (thr_high_reg),
        .level    (level)
    );

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("item taken while previous one in flight");

    a_out_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg) == ST_DONE)
        else $error("result shown without finished run");

    a_run_length: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_RUN && bit_reg == '0 |=> state_reg == ST_DONE)
        else $error("bit loop did not end in done");
`endif

endmodule
